// File: hdl/ttab_pkg.sv
// ----------------------------------------------------------------------------
// ttab_pkg
// Shared types and constants for the direct-mapped transposition table.
// ----------------------------------------------------------------------------
`default_nettype none

package ttab_pkg;

    // Payload field widths
    localparam int HASH_W  = 64;
    localparam int MOVE_W  = 32;
    localparam int DEPTH_W = 6;

    // Configuration register
    localparam int        CFG_W       = 13;
    localparam logic [CFG_W-1:0] CFG_ENTRIES_RST = 13'd4096;
    localparam int        APB_DATA_W  = 32;
    localparam int        APB_ADDR_W  = 3;
    localparam logic      REG_ENTRIES = 1'b0;   // word index of entries_in_use

    // Request codes
    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_PROBE = 1'b1;

    // Parameter defaults
    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int MOVE_BITS_DEF     = 32;
    localparam int DEPTH_LIMIT_DEF   = 63;

    // Remainder unit iteration counter
    localparam int REM_CNT_W = $clog2(HASH_W + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_LOOK,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: hdl/ttab_if.sv
// ----------------------------------------------------------------------------
// ttab_if
// Request and response channel interfaces (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface ttab_req_if;
    import ttab_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [HASH_W-1:0]  pos_key;
    logic [MOVE_W-1:0]  move_code;
    logic [DEPTH_W-1:0] search_depth;

    modport source (
        output valid, req_type, pos_key, move_code, search_depth,
        input  ready
    );
    modport sink (
        input  valid, req_type, pos_key, move_code, search_depth,
        output ready
    );
endinterface

interface ttab_rsp_if;
    import ttab_pkg::*;

    logic              valid;
    logic              ready;
    logic              success;
    logic [MOVE_W-1:0] found_move;

    modport source (
        output valid, success, found_move,
        input  ready
    );
    modport sink (
        input  valid, success, found_move,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/direct_mapped_transposition_table.sv
// ----------------------------------------------------------------------------
// direct_mapped_transposition_table
// Direct-mapped hash table of search results with depth-preferred stores.
//
// Requests arrive on i_req (valid/ready). A store (req_type 0) writes hash,
// move and depth into slot hash % entries_in_use unless that slot is valid
// and holds a greater depth; a probe (req_type 1) hits when the slot is valid
// and its hash matches, and returns the stored move. One response beat per
// request leaves on o_rsp from an output register.
// A request passes the radix-2 remainder unit (one hash bit per cycle), one
// slot read, one compare/write step and the output register load; only then
// does the sequencer return to idle and take the next beat.
// i_req.ready is high only while the sequencer is idle. A response held by a
// stalled receiver does not block the next request; only the one after waits.
// Reset (i_rst_n, synchronous) starts a clearing pass that marks all
// TABLE_ENTRIES slots invalid, one per cycle, before the first request is
// taken. entries_in_use is written over the APB port, byte address 0; the user
// must write it only while no request is in flight, which the block itself
// does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_transposition_table #(
    parameter int TABLE_ENTRIES = ttab_pkg::TABLE_ENTRIES_DEF,
    parameter int MOVE_BITS     = ttab_pkg::MOVE_BITS_DEF,
    parameter int DEPTH_LIMIT   = ttab_pkg::DEPTH_LIMIT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    ttab_req_if.sink                               i_req,
    ttab_rsp_if.source                             o_rsp,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ttab_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [ttab_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [ttab_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import ttab_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int MOD_W   = IDX_W + 1;
    localparam int CMP_W   = (CFG_W > MOD_W) ? CFG_W : MOD_W;
    localparam int DEP_W   = $clog2(DEPTH_LIMIT + 1);
    localparam int DCMP_W  = (DEPTH_W > DEP_W) ? DEPTH_W : DEP_W;
    localparam int WORD_W  = 1 + DEP_W + HASH_W + MOVE_BITS;
    localparam int HASH_LSB = MOVE_BITS;
    localparam int DEP_LSB  = MOVE_BITS + HASH_W;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_entries;
    logic             cfg_sel;

    assign cfg_sel = (paddr[APB_ADDR_W-1] == REG_ENTRIES);
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? APB_DATA_W'(r_entries) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= CFG_ENTRIES_RST;
        end else if (psel && penable && pwrite && cfg_sel) begin
            r_entries <= pwdata[CFG_W-1:0];
        end
    end

    // clamp modulus to 1..TABLE_ENTRIES
    logic [CMP_W-1:0] entries_ext;
    logic [MOD_W-1:0] modulus;

    assign entries_ext = CMP_W'(r_entries);

    always_comb begin
        if (entries_ext == '0) begin
            modulus = MOD_W'(1);
        end else if (entries_ext > CMP_W'(TABLE_ENTRIES)) begin
            modulus = MOD_W'(TABLE_ENTRIES);
        end else begin
            modulus = MOD_W'(entries_ext);
        end
    end

    // ---------------- remainder unit ----------------
    logic             rem_start;
    logic             rem_done;
    logic [IDX_W-1:0] rem_idx;

    ttab_rem #(
        .MOD_W (MOD_W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (i_req.pos_key),
        .i_modulus  (modulus),
        .o_done     (rem_done),
        .o_rem      (rem_idx)
    );

    // ---------------- slot memory ----------------
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [WORD_W-1:0] ram_rdata;

    ttab_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (rem_idx),
        .o_rdata (ram_rdata)
    );

    // ---------------- captured request ----------------
    logic                 r_type;
    logic [HASH_W-1:0]    r_hash;
    logic [MOVE_BITS-1:0] r_move;
    logic [DEP_W-1:0]     r_depth;
    logic [IDX_W-1:0]     r_idx;
    logic [DEP_W-1:0]     depth_sat;

    always_comb begin
        if (DCMP_W'(i_req.search_depth) > DCMP_W'(DEPTH_LIMIT)) begin
            depth_sat = DEP_W'(DEPTH_LIMIT);
        end else begin
            depth_sat = DEP_W'(i_req.search_depth);
        end
    end

    // ---------------- lookup ----------------
    logic                 slot_valid;
    logic [DEP_W-1:0]     slot_depth;
    logic [HASH_W-1:0]    slot_hash;
    logic [MOVE_BITS-1:0] slot_move;
    logic                 store_ok;
    logic                 probe_hit;
    logic                 look_success;
    logic [MOVE_W-1:0]    look_move;

    assign slot_valid = ram_rdata[WORD_W-1];
    assign slot_depth = ram_rdata[DEP_LSB +: DEP_W];
    assign slot_hash  = ram_rdata[HASH_LSB +: HASH_W];
    assign slot_move  = ram_rdata[MOVE_BITS-1:0];
    assign store_ok   = !(slot_valid && (slot_depth > r_depth));
    assign probe_hit  = slot_valid && (slot_hash == r_hash);

    always_comb begin
        if (r_type == REQ_STORE) begin
            look_success = store_ok;
            look_move    = '0;
        end else begin
            look_success = probe_hit;
            look_move    = probe_hit ? MOVE_W'(slot_move) : '0;
        end
    end

    // ---------------- sequencer ----------------
    t_state            r_state;
    t_state            n_state;
    logic [IDX_W-1:0]  r_clr_idx;
    logic              r_res_success;
    logic [MOVE_W-1:0] r_res_move;
    logic              r_out_valid;
    logic              r_out_success;
    logic [MOVE_W-1:0] r_out_move;
    logic              out_free;
    logic              req_ready;

    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {1'b1, r_depth, r_hash, r_move};
        ram_re    = 1'b0;
        rem_start = 1'b0;
        req_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '0;
                if (r_clr_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                req_ready = 1'b1;
                if (i_req.valid) begin
                    rem_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (rem_done) begin
                    ram_re  = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                ram_we  = (r_type == REQ_STORE) && store_ok;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (rem_start) begin
            r_type  <= i_req.req_type;
            r_hash  <= i_req.pos_key;
            r_move  <= MOVE_BITS'(i_req.move_code);
            r_depth <= depth_sat;
        end
        if ((r_state == S_DIV) && rem_done) begin
            r_idx <= rem_idx;
        end
        if (r_state == S_LOOK) begin
            r_res_success <= look_success;
            r_res_move    <= look_move;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_success <= r_res_success;
            r_out_move    <= r_res_move;
        end
    end

    assign i_req.ready      = req_ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.success    = r_out_success;
    assign o_rsp.found_move = r_out_move;

endmodule

`default_nettype wire

// File: hdl/ttab_ram.sv
// ----------------------------------------------------------------------------
// ttab_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/ttab_rem.sv
// ----------------------------------------------------------------------------
// ttab_rem
// Radix-2 restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttab_rem #(
    parameter int MOD_W = 13
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ttab_pkg::HASH_W-1:0] i_dividend,
    input  wire logic [MOD_W-1:0]           i_modulus,
    output logic                            o_done,
    output logic      [MOD_W-2:0]           o_rem
);
    import ttab_pkg::*;

    logic [REM_CNT_W-1:0] r_cnt;
    logic [REM_CNT_W-1:0] n_cnt;
    logic                 r_done;
    logic                 n_done;
    logic [HASH_W-1:0]    r_dvd;
    logic [HASH_W-1:0]    n_dvd;
    logic [MOD_W-2:0]     r_rem;
    logic [MOD_W-2:0]     n_rem;
    logic [MOD_W-1:0]     shifted;

    // remainder stays below the modulus, so one compare-subtract per bit
    assign shifted = {r_rem, r_dvd[HASH_W-1]};

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        if (i_start) begin
            n_cnt = REM_CNT_W'(HASH_W);
            n_dvd = i_dividend;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_dvd = {r_dvd[HASH_W-2:0], 1'b0};
            if (shifted >= i_modulus) begin
                n_rem = (MOD_W-1)'(shifted - i_modulus);
            end else begin
                n_rem = shifted[MOD_W-2:0];
            end
            n_done = (r_cnt == REM_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the direct-mapped transposition table. Stores and
// probes go in on the request channel; a shadow copy of the slot array,
// indexed with the same modulus rules, predicts every response beat.
// Directed corner cases come first, then random traffic built around
// recently stored keys, run under several table sizes with random stalls.
// ----------------------------------------------------------------------------

module tb;
    import ttab_pkg::*;

    localparam int          NUM_SLOTS    = TABLE_ENTRIES_DEF;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          MAX_REPORTS  = 10;
    localparam int          RECENT_MAX   = 48;
    localparam int          PHASE_ITEMS  = 140;
    localparam logic [APB_ADDR_W-1:0] ADDR_ENTRIES = APB_ADDR_W'(REG_ENTRIES) << 2;

    typedef struct packed {
        logic               req_type;
        logic [HASH_W-1:0]  hash;
        logic [MOVE_W-1:0]  move;
        logic [DEPTH_W-1:0] depth;
    } t_tt_req;

    // expected response plus the request that caused it, for reporting
    typedef struct packed {
        logic              success;
        logic [MOVE_W-1:0] found_move;
        logic              req_type;
        logic [HASH_W-1:0] hash;
    } t_tt_result;

    logic clk;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ttab_req_if req_if ();
    ttab_rsp_if rsp_if ();

    direct_mapped_transposition_table u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the slot array and the modulus register
    logic [HASH_W-1:0]  tt_hash  [NUM_SLOTS];
    logic [MOVE_W-1:0]  tt_move  [NUM_SLOTS];
    logic [DEPTH_W-1:0] tt_depth [NUM_SLOTS];
    bit                 tt_valid [NUM_SLOTS];
    logic [CFG_W-1:0]   cfg_entries;

    t_tt_result         pending_rsp [$];
    logic [HASH_W-1:0]  recent_keys [$];

    int  err_count;
    int  n_sent;
    int  n_beats;
    int  n_store_ok;
    int  n_store_rej;
    int  n_hit;
    int  n_miss;
    int  n_sizes;
    bit  src_idle_en;
    bit  rsp_idle_en;
    int  rsp_hold_left;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(64'd8_000_000);
        $display("timeout: %0d responses still outstanding", pending_rsp.size());
        $display("tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [HASH_W-1:0] eff_modulus();
        if (cfg_entries == '0)
            return 64'd1;
        if (cfg_entries > NUM_SLOTS)
            return HASH_W'(NUM_SLOTS);
        return HASH_W'(cfg_entries);
    endfunction

    function automatic int unsigned slot_index(input logic [HASH_W-1:0] h);
        return int'(h % eff_modulus());
    endfunction

    function automatic t_tt_result apply_request(input t_tt_req r);
        t_tt_result         res;
        int unsigned        idx;
        logic [DEPTH_W-1:0] d;
        res          = '0;
        res.req_type = r.req_type;
        res.hash     = r.hash;
        d            = r.depth;
        if (d > DEPTH_LIMIT_DEF)
            d = DEPTH_W'(DEPTH_LIMIT_DEF);
        idx = slot_index(r.hash);
        if (r.req_type == REQ_STORE) begin
            // equal depth replaces, deeper resident wins
            if (!(tt_valid[idx] && tt_depth[idx] > d)) begin
                tt_hash[idx]  = r.hash;
                tt_move[idx]  = r.move;
                tt_depth[idx] = d;
                tt_valid[idx] = 1'b1;
                res.success   = 1'b1;
                n_store_ok++;
            end else begin
                n_store_rej++;
            end
        end else if (tt_valid[idx] && tt_hash[idx] == r.hash) begin
            res.success    = 1'b1;
            res.found_move = tt_move[idx];
            n_hit++;
        end else begin
            n_miss++;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Response side: stalls and checking
    // ------------------------------------------------------------------
    initial begin
        int burst;
        burst = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_hold_left > 0) begin
                rsp_hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                rsp_if.ready <= 1'b0;
            end else if (rsp_idle_en && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 15) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    always @(posedge clk) begin
        t_tt_result want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            n_beats++;
            if (pending_rsp.size() == 0) begin
                note_error($sformatf("unexpected beat success=%0b move=%08h",
                                     rsp_if.success, rsp_if.found_move));
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_if.success !== want.success)
                    note_error($sformatf("%s hash=%016h success exp=%0b got=%0b",
                                         want.req_type == REQ_STORE ? "store" : "probe",
                                         want.hash, want.success, rsp_if.success));
                if (rsp_if.found_move !== want.found_move)
                    note_error($sformatf("%s hash=%016h found_move exp=%08h got=%08h",
                                         want.req_type == REQ_STORE ? "store" : "probe",
                                         want.hash, want.found_move, rsp_if.found_move));
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side and register access
    // ------------------------------------------------------------------
    task automatic send_req(input t_tt_req r);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            // half the gaps start once the block is idle, so they are seen
            if ($urandom_range(0, 1) == 0) begin
                @(posedge clk);
                while (req_if.ready !== 1'b1) @(posedge clk);
            end
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= r.req_type;
        req_if.pos_key      <= r.hash;
        req_if.move_code    <= r.move;
        req_if.search_depth <= r.depth;
        @(posedge clk);
        while (req_if.ready !== 1'b1) @(posedge clk);
        pending_rsp.push_back(apply_request(r));
        n_sent++;
    endtask

    task automatic send_fields(input logic kind, input logic [HASH_W-1:0] h,
                               input logic [MOVE_W-1:0] m, input logic [DEPTH_W-1:0] d);
        t_tt_req r;
        r.req_type = kind;
        r.hash     = h;
        r.move     = m;
        r.depth    = d;
        send_req(r);
    endtask

    task automatic wait_drained();
        while (pending_rsp.size() != 0) @(posedge clk);
    endtask

    // leaves psel high so a second transfer can follow back to back
    task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data,
                            output logic [APB_DATA_W-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        rd = prdata;
    endtask

    task automatic read_check_entries(input logic [CFG_W-1:0] want);
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b0, ADDR_ENTRIES, '0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[CFG_W-1:0] !== want)
            note_error($sformatf("entries_in_use readback exp=%0d got=%0d",
                                 want, rd[CFG_W-1:0]));
    endtask

    task automatic set_entries(input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        req_if.valid <= 1'b0;
        wait_drained();
        while (req_if.ready !== 1'b1) @(posedge clk);
        apb_xfer(1'b1, ADDR_ENTRIES, value, rd);
        cfg_entries = value[CFG_W-1:0];
        read_check_entries(value[CFG_W-1:0]);
        n_sizes++;
    endtask

    function automatic logic [HASH_W-1:0] rand_hash();
        case ($urandom_range(0, 3))
            0:       return HASH_W'($urandom_range(0, 8191));
            1:       return {32'hFFFF_FFFF, 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [HASH_W-1:0] recent_key();
        if (recent_keys.size() == 0)
            return rand_hash();
        return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    endfunction

    // mostly stores and probes of keys stored lately, some same-slot
    // aliases, some noise
    function automatic t_tt_req random_req();
        t_tt_req           r;
        int                pick;
        logic [HASH_W-1:0] n;
        n       = eff_modulus();
        pick    = $urandom_range(0, 99);
        r.move  = 32'($urandom);
        r.depth = $urandom_range(0, 1) ? DEPTH_W'($urandom_range(0, 63))
                                       : DEPTH_W'($urandom_range(28, 36));
        if (pick < 45) begin
            r.req_type = REQ_STORE;
            if (recent_keys.size() != 0 && $urandom_range(0, 2) == 0)
                r.hash = recent_key() + n * HASH_W'($urandom_range(0, 3));
            else
                r.hash = rand_hash();
            recent_keys.push_back(r.hash);
            if (recent_keys.size() > RECENT_MAX)
                void'(recent_keys.pop_front());
        end else if (pick < 85) begin
            r.req_type = REQ_PROBE;
            r.hash     = recent_key();
        end else begin
            r.req_type = REQ_PROBE;
            r.hash     = $urandom_range(0, 1) ? rand_hash()
                                              : recent_key() + n * HASH_W'($urandom_range(1, 3));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        while (req_if.ready !== 1'b1) @(posedge clk);
        read_check_entries(CFG_ENTRIES_RST);
        // zero hash against an empty slot must miss
        send_fields(REQ_PROBE, 64'd0, 32'hFFFF_FFFF, 6'd63);
        send_fields(REQ_STORE, 64'd0, 32'hFFFF_FFFF, 6'd63);
        send_fields(REQ_PROBE, 64'd0, 32'd0, 6'd0);
        // same slot, shallower: refused
        send_fields(REQ_STORE, 64'd4096, 32'h0000_0001, 6'd62);
        send_fields(REQ_PROBE, 64'd4096, 32'd0, 6'd0);
        // same slot, equal depth: replaces
        send_fields(REQ_STORE, 64'd4096, 32'h1234_5678, 6'd63);
        send_fields(REQ_PROBE, 64'd0, 32'd0, 6'd0);
        send_fields(REQ_PROBE, 64'd4096, 32'd0, 6'd0);
        send_fields(REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 6'd0);
        send_fields(REQ_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_fields(REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_A5A5, 6'd0);
        send_fields(REQ_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 6'd0);
        // modulus zero acts as one; old contents of slot 0 stay put
        set_entries(32'd0);
        send_fields(REQ_STORE, 64'h0000_0000_0000_1234, 32'h5A5A_5A5A, 6'd10);
        send_fields(REQ_PROBE, 64'd4096, 32'd0, 6'd0);
        send_fields(REQ_STORE, 64'hDEAD_BEEF_0BAD_F00D, 32'h8000_0000, 6'd63);
        send_fields(REQ_PROBE, 64'hDEAD_BEEF_0BAD_F00D, 32'd0, 6'd0);
        // above the slot count saturates to the full table
        set_entries(32'd8191);
        send_fields(REQ_PROBE, 64'hDEAD_BEEF_0BAD_F00D, 32'd0, 6'd0);
        send_fields(REQ_STORE, 64'd4196, 32'h0000_FFFF, 6'd5);
        send_fields(REQ_PROBE, 64'd100, 32'd0, 6'd0);
        send_fields(REQ_PROBE, 64'd4196, 32'd0, 6'd0);
        set_entries(32'd4096);
        send_fields(REQ_STORE, 64'h5555_5555_5555_5555, 32'hFFFF_0000, 6'd31);
        send_fields(REQ_STORE, 64'h5555_5555_5555_6555, 32'h0F0F_0F0F, 6'd30);
        send_fields(REQ_PROBE, 64'h5555_5555_5555_5555, 32'd0, 6'd0);
    endtask

    // receiver holds off long enough for the block to back up into its input
    task automatic test_backpressure();
        src_idle_en   = 1'b0;
        rsp_hold_left = 400;
        repeat (8) send_req(random_req());
        src_idle_en = 1'b1;
    endtask

    // sender waits for every outstanding beat before the next request
    task automatic test_drained_sends();
        repeat (10) begin
            send_req(random_req());
            // drop valid so the idle block does not take the same beat again
            req_if.valid <= 1'b0;
            wait_drained();
        end
    endtask

    task automatic test_random_sizes();
        logic [APB_DATA_W-1:0] sizes [10];
        sizes = '{32'd1, 32'd2, 32'd7, 32'd64, 32'd0, 32'd8191, 32'd4097, 32'd4095,
                  32'd4096, 32'd0};
        for (int i = 0; i < 10; i++) begin
            if (i == 9) begin
                // closing stretch runs without any stalls
                sizes[i]    = $urandom_range(3, 4096);
                src_idle_en = 1'b0;
                rsp_idle_en = 1'b0;
            end
            set_entries(sizes[i]);
            repeat (PHASE_ITEMS) send_req(random_req());
        end
    endtask

    initial begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_if.valid        = 1'b0;
        req_if.req_type     = REQ_STORE;
        req_if.pos_key      = '0;
        req_if.move_code    = '0;
        req_if.search_depth = '0;
        cfg_entries         = CFG_ENTRIES_RST;
        err_count           = 0;
        n_sent              = 0;
        n_beats             = 0;
        n_store_ok          = 0;
        n_store_rej         = 0;
        n_hit               = 0;
        n_miss              = 0;
        n_sizes             = 0;
        src_idle_en         = 1'b1;
        rsp_idle_en         = 1'b1;
        rsp_hold_left       = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_drained_sends();
        test_random_sizes();

        req_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d requests, %0d beats, %0d table sizes programmed",
                 n_sent, n_beats, n_sizes);
        $display("summary: stores %0d written / %0d refused, probes %0d hit / %0d missed",
                 n_store_ok, n_store_rej, n_hit, n_miss);
        if (err_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("%0d mismatches", err_count);
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/ttab_pkg.sv
hdl/ttab_if.sv
hdl/ttab_ram.sv
hdl/ttab_rem.sv
hdl/direct_mapped_transposition_table.sv
tb/sv/tb.sv
